// ----- rtl/core/gbc_pkg.sv -----
`default_nettype none
package gbc_pkg;

   localparam int ADDR_W   = 15;
   localparam int COLOR_W  = 8;
   localparam int POS_W    = 9;
   localparam int CODE_W   = 8;
   localparam int INDEX_W  = 13;
   localparam int FROW_W   = 11;   // glyph row byte address width
   localparam int COORD_W  = 11;   // screen coordinate with headroom for compares
   localparam int GLYPH_W  = 3;    // column / row counter width, 8x8 glyph

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_DRAW = 1'b1;

   typedef logic [ADDR_W-1:0]          pixel_addr_type;
   typedef logic [COLOR_W-1:0]         color_type;
   typedef logic signed [POS_W-1:0]    pos_type;
   typedef logic signed [COORD_W-1:0]  coord_type;
   typedef logic [GLYPH_W-1:0]         glyph_cnt_type;

endpackage
`default_nettype wire

// ----- rtl/core/gbc_ram.sv -----
`default_nettype none
module gbc_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/core/glyph_blit_8x8_clipped.sv -----
// channel | direction | handshake            | payload
// req     | in        | req_valid, req_stall | func, font_index, font_data, glyph_code,
//         |           |                      | pos_x, pos_y, fore_color, back_color
// rsp     | out       | rsp_valid, rsp_stall | pixel_address, pixel_color, last_pixel
//
// a load item writes its byte to the font RAM and leaves the block ready for the next item
// a draw item first runs its setup (9-step serial multiply of row by screen width,
// the first font fetch rides on its last step) and then walks the 8x8 cell,
// one pixel a cycle while the result is not stalled
// clipped pixels are still walked but not sent out; the font row shifts out one bit per column
// a stalled result freezes the walk; reset is synchronous and clears control state only
`default_nettype none
module glyph_blit_8x8_clipped
   import gbc_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 144,
   parameter int SCREEN_HEIGHT = 168,
   parameter int FONT_BYTES    = 8192
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_func,
   input  wire logic [INDEX_W-1:0]   req_font_index,
   input  wire logic [7:0]           req_font_data,
   input  wire logic [CODE_W-1:0]    req_glyph_code,
   input  wire logic signed [POS_W-1:0] req_pos_x,
   input  wire logic signed [POS_W-1:0] req_pos_y,
   input  wire logic [COLOR_W-1:0]   req_fore_color,
   input  wire logic [COLOR_W-1:0]   req_back_color,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [ADDR_W-1:0]         rsp_pixel_address,
   output logic [COLOR_W-1:0]        rsp_pixel_color,
   output logic                      rsp_last_pixel
);

   localparam int FA_W = $clog2(FONT_BYTES);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;

   localparam logic [3:0] MUL_LAST = 4'(POS_W - 1);

   localparam pixel_addr_type WIDTH_A   = ADDR_W'(SCREEN_WIDTH);
   localparam pixel_addr_type ROW_SKIP  = ADDR_W'(SCREEN_WIDTH - 7);
   localparam coord_type      WIDTH_C   = COORD_W'(SCREEN_WIDTH);
   localparam coord_type      HEIGHT_C  = COORD_W'(SCREEN_HEIGHT);
   localparam coord_type      WIDTH_M1  = COORD_W'(SCREEN_WIDTH - 1);
   localparam coord_type      HEIGHT_M1 = COORD_W'(SCREEN_HEIGHT - 1);
   localparam glyph_cnt_type  CNT_MAX   = '1;

   logic [1:0]          state_ff, state_in;
   logic [3:0]          mul_cnt_ff, mul_cnt_in;
   pixel_addr_type      mcand_ff, mcand_in;
   logic [POS_W-1:0]    mplier_ff, mplier_in;
   pixel_addr_type      pix_addr_ff, pix_addr_in;
   coord_type           px_ff, px_in;
   coord_type           sx_ff, sx_in;
   coord_type           sy_ff, sy_in;
   glyph_cnt_type       col_ff, col_in;
   glyph_cnt_type       row_ff, row_in;
   logic [CODE_W-1:0]   code_ff, code_in;
   color_type           fg_ff, fg_in;
   color_type           bg_ff, bg_in;
   logic [7:0]          bits_ff, bits_in;

   logic                rsp_valid_ff, rsp_valid_in;
   pixel_addr_type      rsp_addr_ff, rsp_addr_in;
   color_type           rsp_color_ff, rsp_color_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                req_take;
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [FA_W-1:0]     ram_rd_addr;
   logic [7:0]          ram_rd_data;
   glyph_cnt_type       fetch_row;
   logic                step;
   logic                visible;
   logic                pix_bit;
   logic                pix_last;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign ram_wr_en = req_take && (req_func == FUNC_LOAD) &&
                      ({1'b0, req_font_index} < (INDEX_W+1)'(FONT_BYTES));

   assign step      = (state_ff == ST_RUN) && (!rsp_valid_ff || !rsp_stall);
   assign visible   = !sx_ff[COORD_W-1] && (sx_ff < WIDTH_C) &&
                      !sy_ff[COORD_W-1] && (sy_ff < HEIGHT_C);
   assign pix_bit   = (col_ff == '0) ? ram_rd_data[7] : bits_ff[7];
   // last column of the cell or of the screen, on the last visible row
   assign pix_last  = ((sx_ff == WIDTH_M1) || (col_ff == CNT_MAX)) &&
                      ((sy_ff == HEIGHT_M1) || (row_ff == CNT_MAX));

   // next row's font byte is fetched while the current row's last column goes out
   assign fetch_row   = (state_ff == ST_MUL) ? '0 : row_ff + 1'b1;
   assign ram_rd_en   = ((state_ff == ST_MUL) && (mul_cnt_ff == MUL_LAST)) ||
                        (step && (col_ff == CNT_MAX));
   assign ram_rd_addr = FA_W'({code_ff[7:2], fetch_row, code_ff[1:0]});

   gbc_ram #(
      .DATA_W (8),
      .DEPTH  (FONT_BYTES)
   ) u_font (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_font_index[FA_W-1:0]),
      .wr_data (req_font_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      mul_cnt_in  = mul_cnt_ff;
      mcand_in    = mcand_ff;
      mplier_in   = mplier_ff;
      pix_addr_in = pix_addr_ff;
      px_in       = px_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      code_in     = code_ff;
      fg_in       = fg_ff;
      bg_in       = bg_ff;
      bits_in     = bits_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_func == FUNC_DRAW)) begin
               state_in    = ST_MUL;
               mul_cnt_in  = '0;
               mcand_in    = WIDTH_A;
               mplier_in   = req_pos_y;
               pix_addr_in = ADDR_W'(req_pos_x);
               px_in       = COORD_W'(req_pos_x);
               sx_in       = COORD_W'(req_pos_x);
               sy_in       = COORD_W'(req_pos_y);
               col_in      = '0;
               row_in      = '0;
               code_in     = req_glyph_code;
               fg_in       = req_fore_color;
               bg_in       = req_back_color;
            end
         end
         ST_MUL: begin
            // shift-add of pos_y by screen width, sign bit weighs negative
            if (mplier_ff[0]) begin
               if (mul_cnt_ff == MUL_LAST) begin
                  pix_addr_in = pix_addr_ff - mcand_ff;
               end else begin
                  pix_addr_in = pix_addr_ff + mcand_ff;
               end
            end
            mcand_in   = {mcand_ff[ADDR_W-2:0], 1'b0};
            mplier_in  = {1'b0, mplier_ff[POS_W-1:1]};
            mul_cnt_in = mul_cnt_ff + 1'b1;
            if (mul_cnt_ff == MUL_LAST) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (step) begin
               bits_in = (col_ff == '0) ? {ram_rd_data[6:0], 1'b0} : {bits_ff[6:0], 1'b0};
               col_in  = col_ff + 1'b1;
               if (col_ff == CNT_MAX) begin
                  row_in      = row_ff + 1'b1;
                  sx_in       = px_ff;
                  sy_in       = sy_ff + 1'b1;
                  pix_addr_in = pix_addr_ff + ROW_SKIP;
                  if (row_ff == CNT_MAX) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  sx_in       = sx_ff + 1'b1;
                  pix_addr_in = pix_addr_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      if (step && visible) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = pix_addr_ff;
         rsp_color_in = pix_bit ? fg_ff : bg_ff;
         rsp_last_in  = pix_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_cnt_ff   <= mul_cnt_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      pix_addr_ff  <= pix_addr_in;
      px_ff        <= px_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      code_ff      <= code_in;
      fg_ff        <= fg_in;
      bg_ff        <= bg_in;
      bits_ff      <= bits_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_address = rsp_addr_ff;
   assign rsp_pixel_color   = rsp_color_ff;
   assign rsp_last_pixel    = rsp_last_ff;

endmodule
`default_nettype wire

// ----- rtl/core/gbc_checker.sv -----
`default_nettype none
module gbc_checker
   import gbc_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire logic                 req_func,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire logic [ADDR_W-1:0]    rsp_pixel_address,
   input wire logic [COLOR_W-1:0]   rsp_pixel_color,
   input wire logic                 rsp_last_pixel
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_address) &&
         $stable(rsp_pixel_color) && $stable(rsp_last_pixel))
      else $error("stalled result changed");

   // a draw item blocks the input while it is rendered
   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_func == FUNC_DRAW) |=> req_stall)
      else $error("input not held off after draw item");

   // a load item completes in its own cycle
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_func == FUNC_LOAD) |=> !req_stall)
      else $error("input held off after load item");

   // setup of a draw produces no pixel in the following cycle
   a_draw_setup: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_func == FUNC_DRAW) && !rsp_valid |=> !rsp_valid)
      else $error("pixel emitted during draw setup");

endmodule

bind glyph_blit_8x8_clipped gbc_checker u_gbc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_func          (req_func),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_pixel_address (rsp_pixel_address),
   .rsp_pixel_color   (rsp_pixel_color),
   .rsp_last_pixel    (rsp_last_pixel)
);
`default_nettype wire

// ----- dv/tb_glyph_blit_8x8_clipped.sv -----
`default_nettype none
module tb_glyph_blit_8x8_clipped
   import gbc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCREEN_W     = 144;
   localparam int SCREEN_H     = 168;
   localparam int FONT_DEPTH   = 8192;
   localparam int RANDOM_ITEMS = 200;
   localparam int DRAIN_CYCLES = 120;
   localparam int IDLE_LIMIT   = 1000;

   typedef struct {
      logic                func;
      logic [INDEX_W-1:0]  font_index;
      logic [7:0]          font_data;
      logic [CODE_W-1:0]   glyph_code;
      pos_type             pos_x;
      pos_type             pos_y;
      color_type           fore_color;
      color_type           back_color;
   } blit_item_type;

   typedef struct {
      pixel_addr_type addr;
      color_type      color;
      logic           last;
   } glyph_pixel_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_func = FUNC_LOAD;
   logic [INDEX_W-1:0]  req_font_index = '0;
   logic [7:0]          req_font_data = '0;
   logic [CODE_W-1:0]   req_glyph_code = '0;
   pos_type             req_pos_x = '0;
   pos_type             req_pos_y = '0;
   color_type           req_fore_color = '0;
   color_type           req_back_color = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   pixel_addr_type      rsp_pixel_address;
   color_type           rsp_pixel_color;
   logic                rsp_last_pixel;

   blit_item_type   blit_backlog[$];
   glyph_pixel_type pending_pixels[$];
   logic [7:0]      font_shadow [FONT_DEPTH];
   bit              font_loaded [FONT_DEPTH];
   int              errors = 0;
   int              idle_cycles = 0;
   int              queued_items = 0;
   int              burst_left = 0;
   int              gap_left = 0;
   int              stall_run = 0;

   glyph_blit_8x8_clipped #(
      .SCREEN_WIDTH  (SCREEN_W),
      .SCREEN_HEIGHT (SCREEN_H),
      .FONT_BYTES    (FONT_DEPTH)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_font_index    (req_font_index),
      .req_font_data     (req_font_data),
      .req_glyph_code    (req_glyph_code),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_fore_color    (req_fore_color),
      .req_back_color    (req_back_color),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_last_pixel    (rsp_last_pixel)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic int glyph_row_index(input logic [CODE_W-1:0] code, input int row);
      return int'(code & 8'd3) + int'(code >> 2) * 32 + row * 4;
   endfunction

   // pixels of one glyph in raster order, clipped to the screen
   function automatic void render_glyph(input logic [CODE_W-1:0] code, input pos_type px,
                                        input pos_type py, input color_type fg,
                                        input color_type bg);
      int              sy;
      int              sx;
      logic [7:0]      row_bits;
      glyph_pixel_type pix;
      glyph_pixel_type held;
      bit              have_held;
      have_held = 1'b0;
      for (int row = 0; row < 8; row++) begin
         sy = int'(py) + row;
         if (sy < 0 || sy >= SCREEN_H) continue;
         row_bits = font_shadow[glyph_row_index(code, row)];
         for (int col = 0; col < 8; col++) begin
            sx = int'(px) + col;
            if (sx < 0 || sx >= SCREEN_W) continue;
            pix.addr  = pixel_addr_type'(sy * SCREEN_W + sx);
            pix.color = row_bits[7 - col] ? fg : bg;
            pix.last  = 1'b0;
            if (have_held) pending_pixels.push_back(held);
            held = pix;
            have_held = 1'b1;
         end
      end
      if (have_held) begin
         held.last = 1'b1;
         pending_pixels.push_back(held);
      end
   endfunction

   task automatic queue_load(input int index, input logic [7:0] data);
      blit_item_type item;
      item = '{func: FUNC_LOAD, font_index: index[INDEX_W-1:0], font_data: data,
               glyph_code: CODE_W'($urandom), pos_x: pos_type'($urandom),
               pos_y: pos_type'($urandom), fore_color: color_type'($urandom),
               back_color: color_type'($urandom)};
      blit_backlog.push_back(item);
      font_loaded[index] = 1'b1;
      queued_items++;
   endtask

   // glyph rows never loaded get random content first
   task automatic queue_draw(input logic [CODE_W-1:0] code, input int px, input int py,
                             input color_type fg, input color_type bg);
      blit_item_type item;
      for (int row = 0; row < 8; row++)
         if (!font_loaded[glyph_row_index(code, row)])
            queue_load(glyph_row_index(code, row), 8'($urandom));
      item = '{func: FUNC_DRAW, font_index: INDEX_W'($urandom), font_data: 8'($urandom),
               glyph_code: code, pos_x: pos_type'(px), pos_y: pos_type'(py),
               fore_color: fg, back_color: bg};
      blit_backlog.push_back(item);
      queued_items++;
   endtask

   initial begin
      int pick;
      int px;
      int py;
      // glyph 0 gets fixed stripes so every column position is exercised
      queue_load(glyph_row_index(8'd0, 0), 8'h80);
      queue_load(glyph_row_index(8'd0, 1), 8'h01);
      queue_load(glyph_row_index(8'd0, 2), 8'hff);
      queue_load(glyph_row_index(8'd0, 3), 8'h00);
      queue_load(glyph_row_index(8'd0, 4), 8'haa);
      queue_load(glyph_row_index(8'd0, 5), 8'h55);
      queue_load(glyph_row_index(8'd0, 6), 8'hc3);
      queue_load(glyph_row_index(8'd0, 7), 8'h3c);
      queue_draw(8'd0, 0, 0, 8'hff, 8'h00);
      queue_draw(8'd0, SCREEN_W - 8, SCREEN_H - 8, 8'h00, 8'hff);
      queue_draw(8'd0, -3, -5, 8'h5a, 8'ha5);
      queue_draw(8'd0, SCREEN_W - 1, SCREEN_H - 1, 8'hff, 8'h01);
      queue_draw(8'd0, -7, -7, 8'h80, 8'h7f);
      queue_draw(8'd0, -8, 20, 8'h11, 8'h22);
      queue_draw(8'd0, 20, SCREEN_H, 8'h33, 8'h44);
      queue_draw(8'd0, -256, -256, 8'h55, 8'h66);
      queue_draw(8'd0, 255, 255, 8'h77, 8'h88);
      queue_load(FONT_DEPTH - 1, 8'hff);
      queue_load(FONT_DEPTH / 2, 8'h00);
      queue_draw(8'd255, 70, 80, 8'h00, 8'hff);

      pick = RANDOM_ITEMS;
      while (queued_items < pick) begin
         case ($urandom_range(0, 9))
            0, 1: queue_load($urandom_range(0, FONT_DEPTH - 1), 8'($urandom));
            2: queue_load(glyph_row_index(8'($urandom), $urandom_range(0, 7)), 8'($urandom));
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  px = int'(pos_type'($urandom));
                  py = int'(pos_type'($urandom));
               end else begin
                  px = $urandom_range(0, SCREEN_W + 15) - 8;
                  py = $urandom_range(0, SCREEN_H + 15) - 8;
               end
               queue_draw(8'($urandom), px, py, 8'($urandom), 8'($urandom));
            end
         endcase
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while ((blit_backlog.size() > 0 || req_valid || pending_pixels.size() > 0) &&
             idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      if (idle_cycles < IDLE_LIMIT)
         repeat (DRAIN_CYCLES) @(posedge clock);
      if (idle_cycles >= IDLE_LIMIT) begin
         errors++;
         $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
      end
      if (pending_pixels.size() > 0) begin
         errors++;
         $display("%0t: %0d pixels expected but never delivered, next addr %0d", $time,
                  pending_pixels.size(), pending_pixels[0].addr);
      end
      if (errors == 0)
         $display("glyph_blit_8x8_clipped verification clean");
      else
         $display("glyph_blit_8x8_clipped verification failed");
      $finish;
   end

   // sender: bursts of items with random gaps
   always @(posedge clock) begin
      blit_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (blit_backlog.size() > 0) begin
            item = blit_backlog.pop_front();
            req_func       <= item.func;
            req_font_index <= item.font_index;
            req_font_data  <= item.font_data;
            req_glyph_code <= item.glyph_code;
            req_pos_x      <= item.pos_x;
            req_pos_y      <= item.pos_y;
            req_fore_color <= item.fore_color;
            req_back_color <= item.back_color;
            req_valid      <= 1'b1;
            if (burst_left == 0) burst_left = $urandom_range(1, 24);
            burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 15)
                                                       : $urandom_range(0, 2);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall and clear segments, now and then a long clear one
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
      end else if (stall_run > 0) begin
         stall_run--;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               rsp_stall <= 1'b0;
               stall_run = $urandom_range(0, 6);
            end
            5, 6, 7: begin
               rsp_stall <= 1'b1;
               stall_run = $urandom_range(0, 4);
            end
            default: begin
               rsp_stall <= 1'b0;
               stall_run = $urandom_range(20, 60);
            end
         endcase
      end
   end

   // results are checked before the item taken on the same edge is predicted
   always @(posedge clock) begin
      glyph_pixel_type want;
      if (!reset) begin
         idle_cycles++;
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            if (pending_pixels.size() == 0) begin
               errors++;
               $display("%0t: unexpected pixel addr %0d color %0d last %0d", $time,
                        rsp_pixel_address, rsp_pixel_color, rsp_last_pixel);
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_pixel_address !== want.addr) begin
                  errors++;
                  $display("%0t: pixel_address expected %0d got %0d", $time, want.addr,
                           rsp_pixel_address);
               end
               if (rsp_pixel_color !== want.color) begin
                  errors++;
                  $display("%0t: pixel_color at %0d expected %0d got %0d", $time,
                           want.addr, want.color, rsp_pixel_color);
               end
               if (rsp_last_pixel !== want.last) begin
                  errors++;
                  $display("%0t: last_pixel at %0d expected %0d got %0d", $time,
                           want.addr, want.last, rsp_last_pixel);
               end
            end
         end
         if (req_valid && !req_stall) begin
            idle_cycles = 0;
            if (req_func == FUNC_LOAD)
               font_shadow[req_font_index] = req_font_data;
            else
               render_glyph(req_glyph_code, req_pos_x, req_pos_y, req_fore_color,
                            req_back_color);
         end
      end
   end

endmodule
`default_nettype wire
